>>> rtl/dbsq_pkg.sv
// Package for the display buffer slot queue.
// Holds the slot count, derived widths, opcodes, status codes and stream field layout.
// Depends on nothing.
package dbsq_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FILL_W     = $clog2(SLOT_COUNT + 1);

    localparam int MASK_W     = 16;
    localparam int OPCODE_W   = 2;
    localparam int SLOTIDX_W  = 4;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    localparam int IN_FIELD_W  = OPCODE_W + SLOTIDX_W;
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = SLOTIDX_W + STATUS_W + 1 + COUNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_GET_FREE    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_QUEUE       = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CONSUME     = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_UNQUEUE_ALL = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd3;

endpackage

>>> rtl/display_buffer_slot_queue_unit.sv
// Display buffer slot queue: one item per handshake, one result per item.
// States after acceptance: queue S_QUEUE, unqueue all S_CLEAR, consume S_POP then S_READ
// (S_POP alone when empty), get free S_SCAN at one slot per cycle; each ends in S_FINISH.
// Throughput: one item at a time; the input is ready again once the result is presented.
// Reset (i_rst_n, synchronous, active low): mask and queued flags clear, FIFO empty,
// slot-available event signaled. FIFO memory contents are undefined until written.
module display_buffer_slot_queue_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel: slot_ready_mask.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dbsq_pkg::MASK_W-1:0]    i_cfg_data,
    // Input beats. tdata fields from bit 0: opcode[1:0], slot_index[5:2], zero fill.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dbsq_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // Result beats. tdata fields from bit 0: result_slot[3:0], status[5:4],
    // event_signaled[6], queued_count[11:7], zero fill.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [dbsq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import dbsq_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_QUEUE  = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    logic [2:0]               r_state, n_state;
    logic [MASK_W-1:0]        r_mask;
    logic [SLOT_COUNT-1:0]    r_queued, n_queued;
    logic [SLOT_W-1:0]        r_head, n_head;
    logic [SLOT_W-1:0]        r_tail, n_tail;
    logic [FILL_W-1:0]        r_fill, n_fill;
    logic                     r_event, n_event;
    logic [SLOTIDX_W-1:0]     r_slot, n_slot;
    logic [SLOT_W-1:0]        r_scan, n_scan;
    logic                     r_found, n_found;
    logic [SLOT_W-1:0]        r_first, n_first;
    logic [SLOTIDX_W-1:0]     r_res, n_res;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic                     r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data, n_out_data;

    // FIFO memory with a registered read port.
    logic [SLOTIDX_W-1:0]     r_fifo_mem [SLOT_COUNT];
    logic [SLOTIDX_W-1:0]     r_rd_data;
    logic                     w_mem_we;

    logic [SLOT_COUNT-1:0]    w_usable;
    logic                     w_accept;
    logic [OPCODE_W-1:0]      w_in_op;
    logic [SLOTIDX_W-1:0]     w_in_slot;
    logic                     w_slot_ok;
    logic [SLOT_W-1:0]        w_slot_idx;
    logic [SLOT_W-1:0]        w_pop_idx;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_op       = s_axis_tdata[OPCODE_W-1:0];
    assign w_in_slot     = s_axis_tdata[IN_FIELD_W-1:OPCODE_W];
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A slot is usable when registered and not already queued; mask bits past
    // the slot count are ignored.
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_usable[i] = (i < MASK_W) ? (r_mask[i[3:0]] && !r_queued[i]) : 1'b0;
        end
    end

    assign w_slot_idx = SLOT_W'(r_slot);
    assign w_slot_ok  = (32'(r_slot) < SLOT_COUNT) && w_usable[w_slot_idx]
                        && (32'(r_fill) < SLOT_COUNT);
    assign w_pop_idx  = SLOT_W'(r_rd_data);
    assign w_mem_we   = (r_state == S_QUEUE) && w_slot_ok;

    always_comb begin
        n_state     = r_state;
        n_queued    = r_queued;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_event     = r_event;
        n_slot      = r_slot;
        n_scan      = r_scan;
        n_found     = r_found;
        n_first     = r_first;
        n_res       = r_res;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // The result register frees up as soon as its beat is taken.
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_slot   = w_in_slot;
                    n_scan   = '0;
                    n_found  = 1'b0;
                    n_first  = '0;
                    n_res    = '0;
                    n_status = ST_OK;
                    case (w_in_op)
                        OP_GET_FREE: n_state = S_SCAN;
                        OP_QUEUE:    n_state = S_QUEUE;
                        OP_CONSUME:  n_state = S_POP;
                        default:     n_state = S_CLEAR;
                    endcase
                end
            end
            S_SCAN: begin
                // One slot per cycle; stop at the second usable slot or the last slot.
                if (w_usable[r_scan] && r_found) begin
                    n_res   = SLOTIDX_W'(r_first);
                    n_state = S_FINISH;
                end else if (r_scan == LAST_SLOT) begin
                    n_event = 1'b0;
                    if (w_usable[r_scan]) begin
                        n_res = SLOTIDX_W'(r_scan);
                    end else if (r_found) begin
                        n_res = SLOTIDX_W'(r_first);
                    end else begin
                        n_status = ST_NO_FREE;
                    end
                    n_state = S_FINISH;
                end else begin
                    if (w_usable[r_scan]) begin
                        n_found = 1'b1;
                        n_first = r_scan;
                    end
                    n_scan = r_scan + 1'b1;
                end
            end
            S_QUEUE: begin
                if (w_slot_ok) begin
                    n_tail               = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
                    n_fill               = r_fill + 1'b1;
                    n_queued[w_slot_idx] = 1'b1;
                    n_res                = r_slot;
                end else begin
                    n_status = ST_REJECTED;
                end
                n_state = S_FINISH;
            end
            S_POP: begin
                // The memory read of the head entry is issued in this cycle.
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                    n_state  = S_FINISH;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_head              = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                n_fill              = r_fill - 1'b1;
                n_queued[w_pop_idx] = 1'b0;
                n_event             = 1'b1;
                n_res               = r_rd_data;
                n_state             = S_FINISH;
            end
            S_CLEAR: begin
                n_queued = '0;
                n_head   = '0;
                n_tail   = '0;
                n_fill   = '0;
                n_event  = 1'b1;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                // Hold here while an older result still waits to be taken.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_DATA_W'({COUNT_W'(r_fill), r_event, r_status, r_res});
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= '0;
            r_queued    <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_event     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_queued    <= n_queued;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_event     <= n_event;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_scan     <= n_scan;
        r_found    <= n_found;
        r_first    <= n_first;
        r_res      <= n_res;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_fifo_mem[r_tail] <= r_slot;
        end
        r_rd_data <= r_fifo_mem[r_head];
    end

`ifndef SYNTHESIS
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= SLOT_COUNT)
        else $error("FIFO fill count exceeds the slot count");

    a_flags_match_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_queued) == 32'(r_fill))
        else $error("Queued flags disagree with the FIFO fill count");

    a_one_item_at_a_time : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("Input accepted again while an item is in progress");
`endif

endmodule

>>> sim/display_buffer_slot_queue_unit_tb.sv
// Self-checking testbench for display_buffer_slot_queue_unit: directed and random slot-pool
// operations, checked beat by beat against an in-bench model of the slot pool and its FIFO.
// Depends on rtl/dbsq_pkg.sv and rtl/display_buffer_slot_queue_unit.sv.
module display_buffer_slot_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbsq_pkg::*;

    // The run is cut off here if it has not finished by then.
    localparam int CYCLE_LIMIT  = 500000;
    // Sized from the slot count to cover a get-free scan, so no beat is still in flight.
    localparam int DRAIN_CYCLES = SLOT_COUNT + 8;
    // Length of the long receiver hold-off that backs the block up into its input.
    localparam int LONG_HOLD    = 300;

    // One input beat: an opcode and the slot it names (only queue uses the slot).
    typedef struct packed {
        logic [SLOTIDX_W-1:0] slot;
        logic [OPCODE_W-1:0]  opcode;
    } t_slot_op;

    // One result beat.
    typedef struct packed {
        logic [COUNT_W-1:0]   queued_count;
        logic                 event_level;
        logic [STATUS_W-1:0]  status;
        logic [SLOTIDX_W-1:0] result_slot;
    } t_slot_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [MASK_W-1:0]     i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // Fields from bit 0: opcode[1:0], slot_index[5:2], zero fill.
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // Fields from bit 0: result_slot[3:0], status[5:4], event_signaled[6],
    // queued_count[11:7], zero fill.
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    display_buffer_slot_queue_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------------------
    // Slot pool model. It holds its own copy of the registered-slot mask, the queued flags,
    // the FIFO and the slot-available event, and is advanced once per accepted input beat.
    // ------------------------------------------------------------------------------------
    logic [MASK_W-1:0]     slot_mask_copy = '0;
    logic [SLOT_COUNT-1:0] queued_copy = '0;
    logic [SLOTIDX_W-1:0]  fifo_copy [SLOT_COUNT];
    int                    head_copy = 0;
    int                    tail_copy = 0;
    int                    fill_copy = 0;
    logic                  event_copy = 1'b1;

    // A slot can be handed out or queued when it is registered and not already queued.
    function automatic logic slot_is_usable(input int s);
        return (s < SLOT_COUNT) && slot_mask_copy[s] && !queued_copy[s];
    endfunction

    function automatic t_slot_result apply_slot_op(input t_slot_op op);
        t_slot_result r;
        int           first_free;
        logic         second_free;
        int           s;
        r = '0;
        case (op.opcode)
            OP_GET_FREE: begin
                // Lowest usable slot is reported but not reserved. The event drops when
                // there is no second usable slot behind it.
                first_free  = -1;
                second_free = 1'b0;
                for (s = 0; s < SLOT_COUNT; s++) begin
                    if (slot_is_usable(s)) begin
                        if (first_free < 0) first_free = s;
                        else second_free = 1'b1;
                    end
                end
                if (!second_free) event_copy = 1'b0;
                if (first_free < 0) r.status = ST_NO_FREE;
                else r.result_slot = first_free[SLOTIDX_W-1:0];
            end
            OP_QUEUE: begin
                if (!slot_is_usable(op.slot) || fill_copy >= SLOT_COUNT) begin
                    r.status = ST_REJECTED;
                end else begin
                    fifo_copy[tail_copy] = op.slot;
                    tail_copy = (tail_copy + 1 >= SLOT_COUNT) ? 0 : tail_copy + 1;
                    fill_copy++;
                    queued_copy[op.slot] = 1'b1;
                    r.result_slot = op.slot;
                end
            end
            OP_CONSUME: begin
                // An empty consume leaves the event where it was.
                if (fill_copy == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.result_slot = fifo_copy[head_copy];
                    head_copy = (head_copy + 1 >= SLOT_COUNT) ? 0 : head_copy + 1;
                    fill_copy--;
                    queued_copy[r.result_slot] = 1'b0;
                    event_copy = 1'b1;
                end
            end
            default: begin
                queued_copy = '0;
                head_copy   = 0;
                tail_copy   = 0;
                fill_copy   = 0;
                event_copy  = 1'b1;
            end
        endcase
        r.event_level  = event_copy;
        r.queued_count = fill_copy[COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Input side. The stimulus process fills op_feed; this driver offers one beat at a time
    // and idles at random with probability src_idle_pct percent per cycle. The expected
    // result is worked out at the edge at which the beat is accepted.
    // ------------------------------------------------------------------------------------
    t_slot_op     op_feed[$];
    t_slot_result pending_results[$];
    t_slot_op     beat_on_bus;
    int           src_idle_pct = 0;
    int           sink_stall_pct = 0;
    int           fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results = {pending_results, apply_slot_op(beat_on_bus)};
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (op_feed.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    beat_on_bus = op_feed.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_DATA_W - IN_FIELD_W){1'b0}},
                                      beat_on_bus.slot, beat_on_bus.opcode};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Output side. Ready drops at random with probability sink_stall_pct percent, and stays
    // low for the whole of a long hold-off. The hold-off is counted in its own process and
    // started by a one-cycle pulse on long_stall_go.
    // ------------------------------------------------------------------------------------
    logic long_stall_go = 1'b0;
    int   hold_left = 0;

    always @(posedge i_clk) begin
        if (long_stall_go) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic check_field(input string fname, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", fname, want_v, got_v);
            fail_count++;
        end
    endtask

    // Every accepted result beat is compared with the oldest outstanding expectation.
    t_slot_result got_result;
    t_slot_result want_result;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_result = m_axis_tdata[OUT_FIELD_W-1:0];
            if (pending_results.size() == 0) begin
                $error("result beat with no outstanding input beat: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want_result = pending_results.pop_front();
                check_field("result_slot", 8'(want_result.result_slot),
                            8'(got_result.result_slot));
                check_field("status", 8'(want_result.status), 8'(got_result.status));
                check_field("event_signaled", 8'(want_result.event_level),
                            8'(got_result.event_level));
                check_field("queued_count", 8'(want_result.queued_count),
                            8'(got_result.queued_count));
            end
        end
    end

    // Watchdog.
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------------------
    task automatic add_op(input logic [OPCODE_W-1:0] opc, input int slot);
        t_slot_op op;
        op.opcode = opc;
        op.slot   = slot[SLOTIDX_W-1:0];
        op_feed = {op_feed, op};
    endtask

    // Waits until every beat has been sent and answered, then lets the drain time pass so
    // the block is surely idle.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (op_feed.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Only called while the block is idle, so the model's mask changes with no beat in flight.
    task automatic write_slot_mask(input logic [MASK_W-1:0] mask);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mask;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        slot_mask_copy = mask;
    endtask

    // Random traffic for one phase. Most of it is well-formed use of the pool: queue
    // registered slots, consume them, ask for free ones. A fill run clears the FIFO, queues
    // every registered slot and then tries once more, which reaches a full FIFO whenever all
    // slots are registered. The rest is noise with any opcode and any slot.
    task automatic make_phase_items(input logic [MASK_W-1:0] mask, input int count);
        int registered[$];
        int order[$];
        int made;
        int pick;
        int i;
        int j;
        int t;
        int w;
        int n_cons;
        for (i = 0; i < SLOT_COUNT; i++) begin
            if (mask[i]) registered = {registered, i};
        end
        made = 0;
        pick = 0;
        while (made < count) begin
            if (pick < 12) begin
                order = registered;
                for (i = order.size() - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    t = order[j];
                    order[j] = order[i];
                    order[i] = t;
                end
                add_op(OP_UNQUEUE_ALL, $urandom_range(0, SLOT_COUNT - 1));
                foreach (order[k]) add_op(OP_QUEUE, order[k]);
                add_op(OP_QUEUE, $urandom_range(0, SLOT_COUNT - 1));
                add_op(OP_GET_FREE, $urandom_range(0, SLOT_COUNT - 1));
                n_cons = $urandom_range(1, order.size() + 1);
                for (i = 0; i < n_cons; i++) add_op(OP_CONSUME, $urandom_range(0, 15));
                made += order.size() + 3 + n_cons;
            end else if (pick < 25) begin
                add_op(OPCODE_W'($urandom_range(0, 3)), $urandom_range(0, SLOT_COUNT - 1));
                made++;
            end else begin
                w = $urandom_range(0, 99);
                if (w < 20) begin
                    add_op(OP_GET_FREE, $urandom_range(0, SLOT_COUNT - 1));
                end else if (w < 60) begin
                    if (registered.size() != 0 && $urandom_range(0, 99) < 90)
                        add_op(OP_QUEUE,
                               registered[$urandom_range(0, registered.size() - 1)]);
                    else
                        add_op(OP_QUEUE, $urandom_range(0, SLOT_COUNT - 1));
                end else if (w < 95) begin
                    add_op(OP_CONSUME, $urandom_range(0, SLOT_COUNT - 1));
                end else begin
                    add_op(OP_UNQUEUE_ALL, $urandom_range(0, SLOT_COUNT - 1));
                end
                made++;
            end
            pick = $urandom_range(0, 99);
        end
    endtask

    // One random phase: new mask while idle, new idling mix, optional long receiver
    // hold-off while the sender keeps offering beats, then a full drain. The drain is also
    // where the sender pauses until every expected result has come back.
    task automatic run_phase(input logic [MASK_W-1:0] mask, input int src_pct,
                             input int sink_pct, input int count, input logic long_hold);
        write_slot_mask(mask);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        if (long_hold) begin
            @(posedge i_clk);
            long_stall_go <= 1'b1;
            @(posedge i_clk);
            long_stall_go <= 1'b0;
        end
        make_phase_items(mask, count);
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, no idling. After reset no slot is registered: nothing is free,
        // consume finds the FIFO empty and queue is rejected for an unregistered slot.
        add_op(OP_GET_FREE, 0);
        add_op(OP_CONSUME, 15);
        add_op(OP_QUEUE, 5);
        add_op(OP_UNQUEUE_ALL, 0);
        wait_idle();

        // All slots registered: queue both end slots, a repeat of one is rejected as
        // already queued, get free skips the queued slot 0, then drain past empty.
        write_slot_mask('1);
        add_op(OP_QUEUE, 0);
        add_op(OP_QUEUE, 15);
        add_op(OP_QUEUE, 15);
        add_op(OP_GET_FREE, 0);
        add_op(OP_CONSUME, 0);
        add_op(OP_CONSUME, 0);
        add_op(OP_CONSUME, 0);
        wait_idle();

        // A single registered slot: get free finds it and clears the event, then once it
        // is queued nothing is free, and an unregistered slot is rejected.
        write_slot_mask(16'h0100);
        add_op(OP_GET_FREE, 15);
        add_op(OP_QUEUE, 8);
        add_op(OP_GET_FREE, 0);
        add_op(OP_QUEUE, 3);
        wait_idle();

        // The mask drops the queued slot: it can still be consumed, but not queued again.
        write_slot_mask('0);
        add_op(OP_CONSUME, 0);
        add_op(OP_QUEUE, 8);
        wait_idle();

        // Random part: several masks, the extremes among them, under each idling mix.
        run_phase('1, 0, 0, 250, 1'b0);
        run_phase(MASK_W'($urandom_range(0, 16'hFFFF)), 58, 0, 250, 1'b0);
        run_phase('1, 0, 58, 250, 1'b1);
        run_phase('0, 16, 16, 100, 1'b0);
        run_phase(MASK_W'($urandom_range(0, 16'hFFFF)), 0, 0, 250, 1'b0);
        run_phase(16'h0001 << $urandom_range(0, SLOT_COUNT - 1), 58, 0, 150, 1'b0);
        run_phase('1, 16, 16, 200, 1'b0);
        run_phase(MASK_W'($urandom_range(0, 16'hFFFF)), 0, 58, 250, 1'b0);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
